FILE: rtl/ttc_pkg.sv
// Package: shared types, constants and calendar helpers for the timestamp converter.
`timescale 1ns / 1ps
`default_nettype none

package ttc_pkg;

	// Sequencer phases of the converter
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DAYS,
		ST_HOURS,
		ST_MINS,
		ST_YEARS,
		ST_MONTHS,
		ST_DONE
	} state_t;

	// Result of the shared compare-subtract unit
	typedef struct packed {
		logic        ge;
		logic [31:0] diff;
	} csub_t;

	localparam int unsigned DataW = 32;
	localparam int unsigned CntW  = 4;

	localparam logic [DataW-1:0] SecsPerDay  = 32'd86400;
	localparam logic [DataW-1:0] SecsPerHour = 32'd3600;
	localparam logic [DataW-1:0] SecsPerMin  = 32'd60;
	localparam logic [DataW-1:0] DaysPerYear = 32'd365;
	localparam logic [DataW-1:0] DaysPerLeap = 32'd366;

	// Top quotient bit index for each long-division phase (bit count minus one)
	localparam logic [CntW-1:0] DayTopBit  = 4'd15;
	localparam logic [CntW-1:0] HourTopBit = 4'd4;
	localparam logic [CntW-1:0] MinTopBit  = 4'd5;

	localparam logic [11:0] BaseYear     = 12'd1970;
	localparam logic [11:0] NonLeapCent  = 12'd2100;
	localparam logic [3:0]  LastMonth    = 4'd11;
	localparam logic [3:0]  FebIdx       = 4'd1;

	// Leap rule over the reachable years 1970..2106: the only century
	// years met are 2000 (leap, divisible by 400) and 2100 (not leap).
	function automatic logic is_leap(input logic [11:0] y);
		logic leap;
		leap = (y[1:0] == 2'b00) && (y != NonLeapCent);
		return leap;
	endfunction

	// Length of a month, index 0 is January
	function automatic logic [DataW-1:0] month_days(input logic [3:0] mon, input logic leap);
		logic [DataW-1:0] len;
		unique case (mon)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 32'd31;
			4'd3, 4'd5, 4'd8, 4'd10:                   len = 32'd30;
			FebIdx:                                    len = leap ? 32'd29 : 32'd28;
			default:                                   len = 32'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/ttc_ifs.sv
// Interfaces: valid/ready channels for the timestamp input and the date output.
`timescale 1ns / 1ps
`default_nettype none

interface ttc_stamp_if;
	logic        valid;
	logic        ready;
	logic [31:0] epoch_seconds;

	modport source (output valid, output epoch_seconds, input ready);
	modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ttc_date_if;
	logic        valid;
	logic        ready;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hours;
	logic [5:0]  minutes;
	logic [5:0]  secs;

	modport source (output valid, output year, output month, output day,
		output hours, output minutes, output secs, input ready);
	modport sink   (input valid, input year, input month, input day,
		input hours, input minutes, input secs, output ready);
endinterface

`default_nettype wire

FILE: rtl/ttc_csub.sv
// Shared compare-subtract unit: difference of two words and a no-borrow flag.
`timescale 1ns / 1ps
`default_nettype none

module ttc_csub (
	input  wire logic [ttc_pkg::DataW-1:0] a,
	input  wire logic [ttc_pkg::DataW-1:0] b,
	output ttc_pkg::csub_t                 res
);

	logic [ttc_pkg::DataW:0] wide;

	// Subtract with one extra bit; the top bit is the borrow
	assign wide     = {1'b0, a} - {1'b0, b};
	assign res.ge   = ~wide[ttc_pkg::DataW];
	assign res.diff = wide[ttc_pkg::DataW-1:0];

endmodule

`default_nettype wire

FILE: rtl/timestamp_to_calendar_date.sv
// Steps: restoring long division for days, hours and minutes, a year walk from 1970,
// a month walk, and a load of the output register.
// One item at a time: a new timestamp is accepted only once the last result has been
// loaded into the output register, which waits for it to drain; all steps share one
// 32-bit compare-subtract unit.
// Reset clears the sequencer and the output valid; no other state needs clearing.
`timescale 1ns / 1ps
`default_nettype none

module timestamp_to_calendar_date (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ttc_stamp_if.sink  stamp,
	ttc_date_if.source date
);

	ttc_pkg::state_t state_q, state_d;

	logic [ttc_pkg::DataW-1:0] acc_q;
	logic [15:0]               quot_q;
	logic [ttc_pkg::CntW-1:0]  cnt_q;
	logic [15:0]               days_q;
	logic [4:0]                hours_q;
	logic [5:0]                minutes_q;
	logic [5:0]                secs_q;
	logic [11:0]               year_q;
	logic [3:0]                mon_q;

	logic                      out_valid_q;
	logic [11:0]               out_year_q;
	logic [3:0]                out_month_q;
	logic [4:0]                out_day_q;
	logic [4:0]                out_hours_q;
	logic [5:0]                out_minutes_q;
	logic [5:0]                out_secs_q;

	logic [ttc_pkg::DataW-1:0] operand;
	ttc_pkg::csub_t            sub;
	logic                      leap;
	logic                      accept;
	logic                      load_out;
	logic                      out_free;
	logic [15:0]               quot_next;
	logic                      cnt_last;
	logic                      month_stop;

	ttc_csub u_csub (
		.a   (acc_q),
		.b   (operand),
		.res (sub)
	);

	assign leap       = ttc_pkg::is_leap(year_q);
	assign accept     = stamp.valid && stamp.ready;
	assign out_free   = !out_valid_q || date.ready;
	assign quot_next  = {quot_q[14:0], sub.ge};
	assign cnt_last   = (cnt_q == '0);
	assign month_stop = (mon_q == ttc_pkg::LastMonth) || !sub.ge;

	// Select the subtrahend for the shared unit and drive the handshakes
	always_comb begin
		operand     = '0;
		stamp.ready = 1'b0;
		load_out    = 1'b0;
		unique case (state_q)
			ttc_pkg::ST_IDLE:   stamp.ready = 1'b1;
			ttc_pkg::ST_DAYS:   operand = ttc_pkg::SecsPerDay << cnt_q;
			ttc_pkg::ST_HOURS:  operand = ttc_pkg::SecsPerHour << cnt_q;
			ttc_pkg::ST_MINS:   operand = ttc_pkg::SecsPerMin << cnt_q;
			ttc_pkg::ST_YEARS:  operand = leap ? ttc_pkg::DaysPerLeap : ttc_pkg::DaysPerYear;
			ttc_pkg::ST_MONTHS: operand = ttc_pkg::month_days(mon_q, leap);
			ttc_pkg::ST_DONE:   load_out = out_free;
			default:            operand = '0;
		endcase
	end

	// Advance the sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ttc_pkg::ST_IDLE:   if (accept) state_d = ttc_pkg::ST_DAYS;
			ttc_pkg::ST_DAYS:   if (cnt_last) state_d = ttc_pkg::ST_HOURS;
			ttc_pkg::ST_HOURS:  if (cnt_last) state_d = ttc_pkg::ST_MINS;
			ttc_pkg::ST_MINS:   if (cnt_last) state_d = ttc_pkg::ST_YEARS;
			ttc_pkg::ST_YEARS:  if (!sub.ge) state_d = ttc_pkg::ST_MONTHS;
			ttc_pkg::ST_MONTHS: if (month_stop) state_d = ttc_pkg::ST_DONE;
			ttc_pkg::ST_DONE:   if (out_free) state_d = ttc_pkg::ST_IDLE;
			default:            state_d = ttc_pkg::ST_IDLE;
		endcase
	end

	// Hold control state: phase, bit counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ttc_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ttc_pkg::ST_IDLE:  if (accept) cnt_q <= ttc_pkg::DayTopBit;
				ttc_pkg::ST_DAYS:  cnt_q <= cnt_last ? ttc_pkg::HourTopBit : cnt_q - 1'b1;
				ttc_pkg::ST_HOURS: cnt_q <= cnt_last ? ttc_pkg::MinTopBit : cnt_q - 1'b1;
				ttc_pkg::ST_MINS:  if (!cnt_last) cnt_q <= cnt_q - 1'b1;
				default:           cnt_q <= cnt_q;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (date.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Work registers: restoring division, then year and month walk
	always_ff @(posedge clk) begin
		unique case (state_q)
			ttc_pkg::ST_IDLE: begin
				if (accept) begin
					acc_q  <= stamp.epoch_seconds;
					quot_q <= '0;
				end
			end
			ttc_pkg::ST_DAYS: begin
				if (sub.ge) acc_q <= sub.diff;
				quot_q <= cnt_last ? '0 : quot_next;
				if (cnt_last) days_q <= quot_next;
			end
			ttc_pkg::ST_HOURS: begin
				if (sub.ge) acc_q <= sub.diff;
				quot_q <= cnt_last ? '0 : quot_next;
				if (cnt_last) hours_q <= quot_next[4:0];
			end
			ttc_pkg::ST_MINS: begin
				quot_q <= quot_next;
				if (cnt_last) begin
					minutes_q <= quot_next[5:0];
					secs_q    <= sub.ge ? sub.diff[5:0] : acc_q[5:0];
					acc_q     <= {16'b0, days_q};
					year_q    <= ttc_pkg::BaseYear;
				end else if (sub.ge) begin
					acc_q <= sub.diff;
				end
			end
			ttc_pkg::ST_YEARS: begin
				if (sub.ge) begin
					acc_q  <= sub.diff;
					year_q <= year_q + 12'd1;
				end else begin
					mon_q <= '0;
				end
			end
			ttc_pkg::ST_MONTHS: begin
				if (!month_stop) begin
					acc_q <= sub.diff;
					mon_q <= mon_q + 4'd1;
				end
			end
			ttc_pkg::ST_DONE: begin
				if (load_out) begin
					out_year_q    <= year_q;
					out_month_q   <= mon_q + 4'd1;
					out_day_q     <= acc_q[4:0] + 5'd1;
					out_hours_q   <= hours_q;
					out_minutes_q <= minutes_q;
					out_secs_q    <= secs_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign date.valid   = out_valid_q;
	assign date.year    = out_year_q;
	assign date.month   = out_month_q;
	assign date.day     = out_day_q;
	assign date.hours   = out_hours_q;
	assign date.minutes = out_minutes_q;
	assign date.secs    = out_secs_q;

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ttc_pkg::ST_DAYS)
		else $error("accepted item did not start the day division");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ttc_pkg::ST_MONTHS |-> year_q >= 12'd1970 && year_q <= 12'd2106)
		else $error("year walk left the reachable range");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ttc_pkg::ST_MONTHS |-> mon_q <= ttc_pkg::LastMonth)
		else $error("month walk ran past December");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		date.valid |-> date.month >= 4'd1 && date.month <= 4'd12 && date.day >= 5'd1)
		else $error("date result out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		date.valid |-> date.hours < 5'd24 && date.minutes < 6'd60 && date.secs < 6'd60)
		else $error("time of day result out of range");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Testbench: feeds Unix timestamps into the calendar converter and checks every date it returns.
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned SecsDay     = 86400;
	localparam int unsigned NumPhases   = 4;
	localparam int unsigned PhaseItems  = 470;
	localparam int unsigned DrainLimit  = 5000;
	localparam int unsigned SettleCycles = 250;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  secs;
	} cal_date_t;

	typedef struct packed {
		logic [31:0] stamp;
		logic        known;
		cal_date_t   date;
	} stim_row_t;

	typedef struct packed {
		logic [31:0] stamp;
		cal_date_t   date;
	} pending_date_t;

	logic clk;
	logic arst_n;

	ttc_stamp_if stamp_ch ();
	ttc_date_if  date_ch ();

	timestamp_to_calendar_date DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.stamp (stamp_ch),
		.date  (date_ch)
	);

	pending_date_t pending_dates[$];
	int unsigned   mismatch_count;
	int unsigned   in_gap_pct;
	int unsigned   stall_pct;
	int unsigned   ready_hold;
	int unsigned   month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	stim_row_t     directed_rows [16];

	// Full Gregorian rule: every 4th year, except centuries not divisible by 400
	function automatic bit leap_year(input int unsigned y);
		return ((y % 400) == 0) || (((y % 100) != 0) && ((y % 4) == 0));
	endfunction

	function automatic int unsigned year_len(input int unsigned y);
		return leap_year(y) ? 366 : 365;
	endfunction

	// Predict the calendar date of a timestamp
	function automatic cal_date_t calendar_of(input logic [31:0] stamp);
		cal_date_t   r;
		int unsigned t;
		int unsigned days;
		int unsigned rem;
		int unsigned yr;
		int unsigned mon;
		int unsigned mlen;
		t = stamp;
		days = t / SecsDay;
		rem = t % SecsDay;
		r.hours = 5'(rem / 3600);
		r.minutes = 6'((rem % 3600) / 60);
		r.secs = 6'(rem % 60);
		yr = 1970;
		while (days >= year_len(yr)) begin
			days -= year_len(yr);
			yr++;
		end
		mon = 0;
		while (mon < 11) begin
			mlen = (mon == 1 && leap_year(yr)) ? 29 : month_len[mon];
			if (days < mlen)
				break;
			days -= mlen;
			mon++;
		end
		r.year = 12'(yr);
		r.month = 4'(mon + 1);
		r.day = 5'(days + 1);
		return r;
	endfunction

	// Pick a timestamp of a random year, mostly close to the end of February or a year edge
	function automatic logic [31:0] near_boundary_stamp();
		longint unsigned days;
		longint unsigned total;
		int unsigned     yr;
		int unsigned     offs;
		int unsigned     sod;
		yr = $urandom_range(1970, 2106);
		days = 0;
		for (int unsigned y = 1970; y < yr; y++)
			days += 64'(year_len(y));
		case ($urandom_range(0, 3))
			0: offs = $urandom_range(57, 61);
			1: offs = $urandom_range(363, 366);
			2: offs = $urandom_range(0, 1);
			default: offs = $urandom_range(0, 365);
		endcase
		sod = $urandom_range(0, 1) ? $urandom_range(86390, 86399) : $urandom_range(0, 86399);
		total = (days + 64'(offs)) * 64'(SecsDay) + 64'(sod);
		if (total > 64'hFFFF_FFFF)
			total = 64'hFFFF_FFFF - 64'($urandom_range(0, SecsDay * 30));
		return total[31:0];
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(1, 3);
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got, input logic [31:0] stamp);
		if (want != got) begin
			$error("stamp %0d: %s expected %0d, got %0d", stamp, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Offer one timestamp and hold it until accepted
	task automatic send_stamp(input logic [31:0] stamp, input logic known, input cal_date_t date);
		int unsigned gap;
		gap = ($urandom_range(0, 99) < in_gap_pct) ? pick_gap() : 0;
		if (gap > 0) begin
			stamp_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		stamp_ch.valid <= 1'b1;
		stamp_ch.epoch_seconds <= stamp;
		do
			@(posedge clk);
		while (!stamp_ch.ready);
		pending_dates.push_back('{stamp, known ? date : calendar_of(stamp)});
		@(negedge clk);
	endtask

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the result side at random
	initial begin
		date_ch.ready <= 1'b0;
		ready_hold = 0;
		forever begin
			@(negedge clk);
			if (ready_hold > 0) begin
				date_ch.ready <= 1'b0;
				ready_hold--;
			end else begin
				date_ch.ready <= 1'b1;
				if ($urandom_range(0, 99) < stall_pct)
					ready_hold = pick_gap();
			end
		end
	end

	// Compare each returned date with the oldest prediction
	always @(posedge clk) begin
		pending_date_t want;
		if (arst_n && date_ch.valid && date_ch.ready) begin
			if (pending_dates.size() == 0) begin
				$error("date %0d-%0d-%0d %0d:%0d:%0d with nothing pending", date_ch.year,
					date_ch.month, date_ch.day, date_ch.hours, date_ch.minutes, date_ch.secs);
				mismatch_count++;
			end else begin
				want = pending_dates.pop_front();
				check_field("year", 32'(want.date.year), 32'(date_ch.year), want.stamp);
				check_field("month", 32'(want.date.month), 32'(date_ch.month), want.stamp);
				check_field("day", 32'(want.date.day), 32'(date_ch.day), want.stamp);
				check_field("hours", 32'(want.date.hours), 32'(date_ch.hours), want.stamp);
				check_field("minutes", 32'(want.date.minutes), 32'(date_ch.minutes),
					want.stamp);
				check_field("secs", 32'(want.date.secs), 32'(date_ch.secs), want.stamp);
			end
		end
	end

	// Hard stop in case the block hangs
	initial begin
		#50_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Main sequence: reset, directed table, random phases, drain
	initial begin
		logic [31:0] stamp;
		int unsigned wait_cycles;
		mismatch_count = 0;
		in_gap_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		stamp_ch.valid <= 1'b0;
		stamp_ch.epoch_seconds <= '0;

		directed_rows = '{
			'{32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
			'{32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15}},
			'{32'd86399,      1'b1, '{12'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59}},
			'{32'd86400,      1'b1, '{12'd1970, 4'd1, 5'd2, 5'd0, 6'd0, 6'd0}},
			'{32'd31535999,   1'b0, '0},
			'{32'd68169600,   1'b0, '0},
			'{32'd94694399,   1'b0, '0},
			'{32'd946684799,  1'b0, '0},
			'{32'd951782400,  1'b0, '0},
			'{32'd951868800,  1'b0, '0},
			'{32'd4107542399, 1'b0, '0},
			'{32'd4107542400, 1'b0, '0},
			'{32'h7FFF_FFFF,  1'b0, '0},
			'{32'h8000_0000,  1'b0, '0},
			'{32'hAAAA_AAAA,  1'b0, '0},
			'{32'h5555_5555,  1'b0, '0}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rows: extremes, leap days, century years, bit patterns
		foreach (directed_rows[i])
			send_stamp(directed_rows[i].stamp, directed_rows[i].known, directed_rows[i].date);

		// Random phases with different idle mixes, the first with none
		for (int unsigned ph = 0; ph < NumPhases; ph++) begin
			case (ph)
				0: begin in_gap_pct = 0;  stall_pct = 0;  end
				1: begin in_gap_pct = 30; stall_pct = 30; end
				2: begin in_gap_pct = 10; stall_pct = 60; end
				default: begin in_gap_pct = 60; stall_pct = 10; end
			endcase
			for (int unsigned n = 0; n < PhaseItems; n++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: stamp = $urandom();
					5, 6, 7: stamp = near_boundary_stamp();
					default: stamp = $urandom_range(0, SecsDay * 800);
				endcase
				send_stamp(stamp, 1'b0, '0);
			end
		end
		stamp_ch.valid <= 1'b0;

		// Drain outstanding dates, then watch for strays
		wait_cycles = 0;
		while (pending_dates.size() != 0 && wait_cycles < DrainLimit) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (pending_dates.size() != 0) begin
			$error("%0d dates never returned", pending_dates.size());
			mismatch_count++;
		end
		repeat (SettleCycles) @(posedge clk);

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
